@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl, used by the controller core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clk edge, off while rst is high
`define SDRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every rising clk edge, reset included
`define SDRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/sdrc_pkg.sv @@
// shared constants, codes and types of the straight drive ramp controller
package sdrc_pkg;

  // encoder count width default
  localparam int COUNT_WIDTH_DEF = 24;

  // internal widths
  localparam int TGT_W  = 20;  // pulse target
  localparam int RAMP_W = 16;  // ramp-down length
  localparam int DIV_DVD_W = 24;
  localparam int DIV_DVS_W = 16;

  // ramp is at most one fifth of the target
  localparam int RAMP_FRACTION_DIV = 5;

  // configuration port
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_PULSES_PER_CM  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASE_SPEED     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_SPEED      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HEADING_GAIN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MOVE_TIMEOUT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STALL_TIMEOUT  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RAMP_CAP_CM    = 3'd6;

  localparam logic [15:0] RST_PULSES_PER_CM = 16'd10240;
  localparam logic [7:0]  RST_BASE_SPEED    = 8'd200;
  localparam logic [7:0]  RST_MIN_SPEED     = 8'd100;
  localparam logic [7:0]  RST_HEADING_GAIN  = 8'd80;
  localparam logic [15:0] RST_MOVE_TIMEOUT  = 16'd10000;
  localparam logic [15:0] RST_STALL_TIMEOUT = 16'd1000;
  localparam logic [7:0]  RST_RAMP_CAP_CM   = 8'd15;

  // item function codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // end reason codes
  localparam logic [2:0] REASON_NONE    = 3'd0;
  localparam logic [2:0] REASON_REACHED = 3'd1;
  localparam logic [2:0] REASON_STOP    = 3'd2;
  localparam logic [2:0] REASON_TIMEOUT = 3'd3;
  localparam logic [2:0] REASON_STALL   = 3'd4;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hw/rtl/straight_drive_ramp_controller_core.sv @@
// top level of the straight drive ramp controller: sequencer, datapath and registers
//
// usage
//   input channel (in_valid / in_stall) carries one transaction per item: a start
//   (func = 1) with signed distance and peak speed request, or a one millisecond
//   tick (func = 0) with encoder counts, gyro heading and stop request
//   output channel (out_valid / out_stall) returns exactly one result transaction
//   per input transaction: signed left/right drive, moving, brake, end reason
//   registers are to be written over the apb-style port only while the block is
//   idle; the user must keep to this, the block itself does not enforce it
// datapath and input handshake
//   a start runs target / 5 on the shared 24-step divider, a tick inside the ramp
//   zone runs the ramp interpolation on it, and the single 16x16 multiplier is
//   reused for every product
//   in_stall is high from acceptance until the result enters the output register,
//   so the next transaction is taken in the following cycle at the earliest
// reset
//   rst is synchronous: no move is active, registers take their defaults
// back pressure
//   a finished result waits in the output register while out_stall is high; the
//   next transaction may already be taken and worked on, and its result waits
//   in the final step until the output register is free
`include "assert_macros.svh"

module straight_drive_ramp_controller_core #(
  parameter int COUNT_WIDTH = sdrc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic signed [15:0]            distance_cm,
  input  logic [7:0]                    peak_speed_request,
  input  logic signed [COUNT_WIDTH-1:0] left_count,
  input  logic signed [COUNT_WIDTH-1:0] right_count,
  input  logic signed [15:0]            heading,
  input  logic                          stop_request,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [8:0]             left_drive,
  output logic signed [8:0]             right_drive,
  output logic                          moving,
  output logic                          brake,
  output logic [2:0]                    end_reason,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdrc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int TGT_W  = sdrc_pkg::TGT_W;
  localparam int RAMP_W = sdrc_pkg::RAMP_W;
  localparam int DVD_W  = sdrc_pkg::DIV_DVD_W;
  localparam int DVS_W  = sdrc_pkg::DIV_DVS_W;
  // signed room for target minus position
  localparam int REM_W  = ((COUNT_WIDTH > TGT_W) ? COUNT_WIDTH : TGT_W) + 1;

  typedef enum logic [3:0] {
    IDLE,       // waiting for a transaction
    S_MUL_T,    // start: |distance| * pulses_per_cm
    S_MUL_CAP,  // start: ramp_cap_cm * pulses_per_cm
    S_DIV,      // start: launch target / 5
    S_DIVW,     // start: wait for divider, commit the move
    T_POS,      // tick: position, |heading| * gain
    T_EVAL,     // tick: end checks, progress, counters
    T_MULR,     // tick: remaining * |peak - min|
    T_DIVS,     // tick: launch product / ramp
    T_DIVW,     // tick: wait for divider, ramp speed
    T_DRIVE,    // tick: heading correction, clamp, direction
    FIN         // hand the result to the output register
  } state_t;

  state_t state;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] pulses_per_cm;
  logic [7:0]  base_speed;
  logic [7:0]  min_speed;
  logic [7:0]  heading_gain;
  logic [15:0] move_timeout_ticks;
  logic [15:0] stall_timeout_ticks;
  logic [7:0]  ramp_cap_cm;

  logic [sdrc_pkg::REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[sdrc_pkg::ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_cm       <= sdrc_pkg::RST_PULSES_PER_CM;
      base_speed          <= sdrc_pkg::RST_BASE_SPEED;
      min_speed           <= sdrc_pkg::RST_MIN_SPEED;
      heading_gain        <= sdrc_pkg::RST_HEADING_GAIN;
      move_timeout_ticks  <= sdrc_pkg::RST_MOVE_TIMEOUT;
      stall_timeout_ticks <= sdrc_pkg::RST_STALL_TIMEOUT;
      ramp_cap_cm         <= sdrc_pkg::RST_RAMP_CAP_CM;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        sdrc_pkg::REG_PULSES_PER_CM: pulses_per_cm       <= pwdata[15:0];
        sdrc_pkg::REG_BASE_SPEED:    base_speed          <= pwdata[7:0];
        sdrc_pkg::REG_MIN_SPEED:     min_speed           <= pwdata[7:0];
        sdrc_pkg::REG_HEADING_GAIN:  heading_gain        <= pwdata[7:0];
        sdrc_pkg::REG_MOVE_TIMEOUT:  move_timeout_ticks  <= pwdata[15:0];
        sdrc_pkg::REG_STALL_TIMEOUT: stall_timeout_ticks <= pwdata[15:0];
        sdrc_pkg::REG_RAMP_CAP_CM:   ramp_cap_cm         <= pwdata[7:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sdrc_pkg::REG_PULSES_PER_CM: prdata = {16'd0, pulses_per_cm};
      sdrc_pkg::REG_BASE_SPEED:    prdata = {24'd0, base_speed};
      sdrc_pkg::REG_MIN_SPEED:     prdata = {24'd0, min_speed};
      sdrc_pkg::REG_HEADING_GAIN:  prdata = {24'd0, heading_gain};
      sdrc_pkg::REG_MOVE_TIMEOUT:  prdata = {16'd0, move_timeout_ticks};
      sdrc_pkg::REG_STALL_TIMEOUT: prdata = {16'd0, stall_timeout_ticks};
      sdrc_pkg::REG_RAMP_CAP_CM:   prdata = {24'd0, ramp_cap_cm};
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // move state
  // ---------------------------------------------------------------------------
  logic                   active;
  logic                   reverse;
  logic [TGT_W-1:0]       target_pulses;
  logic [RAMP_W-1:0]      ramp_pulses;
  logic [7:0]             peak_speed;
  logic [15:0]            elapsed_ticks;
  logic [COUNT_WIDTH-1:0] last_progress_pos;
  logic [15:0]            ticks_since_progress;

  // latched transaction
  logic [15:0]            dist_q;
  logic [7:0]             req_q;
  logic [COUNT_WIDTH-1:0] lc_q;
  logic [COUNT_WIDTH-1:0] rc_q;
  logic [15:0]            hd_q;
  logic                   stop_q;

  // working registers
  logic [COUNT_WIDTH-1:0] pos;
  logic [TGT_W-1:0]       t_reg;
  logic [RAMP_W-1:0]      cap_reg;
  logic [RAMP_W-1:0]      rem_lo;
  logic [7:0]             span_mag;
  logic                   span_neg;
  logic [7:0]             speed;
  logic signed [12:0]     corr;

  // pending result
  logic [8:0] res_left;
  logic [8:0] res_right;
  logic       res_moving;
  logic       res_brake;
  logic [2:0] res_reason;

  // ---------------------------------------------------------------------------
  // shared multiplier, one product per cycle, operands picked by the sequencer
  // ---------------------------------------------------------------------------
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] prod;
  logic [15:0] dist_mag;
  logic [15:0] hd_mag;

  assign dist_mag = dist_q[15] ? (~dist_q + 16'd1) : dist_q;
  assign hd_mag   = hd_q[15] ? (~hd_q + 16'd1) : hd_q;

  always_comb begin
    case (state)
      S_MUL_T: begin
        mul_a = dist_mag;
        mul_b = pulses_per_cm;
      end
      S_MUL_CAP: begin
        mul_a = {8'd0, ramp_cap_cm};
        mul_b = pulses_per_cm;
      end
      T_POS: begin
        mul_a = hd_mag;
        mul_b = {8'd0, heading_gain};
      end
      T_MULR: begin
        mul_a = rem_lo;
        mul_b = {8'd0, span_mag};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------------------
  // shared divider: target / 5 on start, ramp interpolation on tick
  // ---------------------------------------------------------------------------
  logic                div_start;
  logic [DVD_W-1:0]    div_dividend;
  logic [DVS_W-1:0]    div_divisor;
  logic [DVD_W-1:0]    div_quo;
  sdrc_pkg::div_stat_t div_stat;

  assign div_start    = (state == S_DIV) || (state == T_DIVS);
  assign div_dividend = (state == S_DIV) ? DVD_W'(t_reg) : prod[DVD_W-1:0];
  assign div_divisor  = (state == S_DIV) ? DVS_W'(sdrc_pkg::RAMP_FRACTION_DIV)
                                         : DVS_W'(ramp_pulses);

  sdrc_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // ---------------------------------------------------------------------------
  // tick evaluation
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0]   lc_mag;
  logic [COUNT_WIDTH-1:0]   rc_mag;
  logic signed [REM_W-1:0]  rem_s;
  logic                     rem_le0;
  logic                     rem_in_ramp;
  logic signed [COUNT_WIDTH:0] diff_s;
  logic [COUNT_WIDTH:0]     diff_mag;
  logic                     progress;
  logic [2:0]               eval_reason;

  assign lc_mag = lc_q[COUNT_WIDTH-1] ? (~lc_q + COUNT_WIDTH'(1)) : lc_q;
  assign rc_mag = rc_q[COUNT_WIDTH-1] ? (~rc_q + COUNT_WIDTH'(1)) : rc_q;

  assign rem_s       = $signed(REM_W'(target_pulses)) - $signed(REM_W'(pos));
  assign rem_le0     = rem_s[REM_W-1] || (rem_s == '0);
  // only looked at when remaining is positive
  assign rem_in_ramp = rem_s[REM_W-2:0] < (REM_W-1)'(ramp_pulses);

  assign diff_s   = $signed({1'b0, pos}) - $signed({1'b0, last_progress_pos});
  assign diff_mag = diff_s[COUNT_WIDTH] ? (~diff_s + (COUNT_WIDTH+1)'(1)) : diff_s;
  // diff * 512 > pulses_per_cm  <=>  diff > pulses_per_cm / 512
  assign progress = diff_mag > (COUNT_WIDTH+1)'(pulses_per_cm[15:9]);

  // end checks in priority order
  always_comb begin
    if (rem_le0) begin
      eval_reason = sdrc_pkg::REASON_REACHED;
    end else if (stop_q) begin
      eval_reason = sdrc_pkg::REASON_STOP;
    end else if (elapsed_ticks > move_timeout_ticks) begin
      eval_reason = sdrc_pkg::REASON_TIMEOUT;
    end else if (!progress && (ticks_since_progress > stall_timeout_ticks)) begin
      eval_reason = sdrc_pkg::REASON_STALL;
    end else begin
      eval_reason = sdrc_pkg::REASON_NONE;
    end
  end

  // heading correction and clamp
  logic signed [13:0] l_raw;
  logic signed [13:0] r_raw;
  logic [7:0]         l_mag;
  logic [7:0]         r_mag;

  function automatic logic [7:0] clamp_drive(input logic signed [13:0] v);
    if (v < 14'sd0) begin
      return 8'd0;
    end else if (v > 14'sd255) begin
      return 8'hFF;
    end else begin
      return v[7:0];
    end
  endfunction

  assign l_raw = $signed({6'd0, speed}) - $signed({corr[12], corr});
  assign r_raw = $signed({6'd0, speed}) + $signed({corr[12], corr});
  assign l_mag = clamp_drive(l_raw);
  assign r_mag = clamp_drive(r_raw);

  assign in_stall = (state != IDLE);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= IDLE;
      out_valid            <= 1'b0;
      active               <= 1'b0;
      reverse              <= 1'b0;
      target_pulses        <= '0;
      ramp_pulses          <= '0;
      peak_speed           <= '0;
      elapsed_ticks        <= '0;
      last_progress_pos    <= '0;
      ticks_since_progress <= '0;
    end else begin
      // output register drains independently of the sequencer; in the final
      // step the refill below takes care of it
      if (out_valid && !out_stall && (state != FIN)) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (in_valid) begin
            dist_q <= distance_cm;
            req_q  <= peak_speed_request;
            lc_q   <= left_count;
            rc_q   <= right_count;
            hd_q   <= heading;
            stop_q <= stop_request;
            state  <= (func == sdrc_pkg::FUNC_START) ? S_MUL_T : T_POS;
          end
        end

        S_MUL_T: begin
          if (dist_q == 16'd0) begin
            // zero distance start leaves the move alone
            res_left   <= '0;
            res_right  <= '0;
            res_moving <= active;
            res_brake  <= 1'b0;
            res_reason <= sdrc_pkg::REASON_NONE;
            state      <= FIN;
          end else begin
            state <= S_MUL_CAP;
          end
        end

        S_MUL_CAP: begin
          t_reg <= prod[31:12];
          state <= S_DIV;
        end

        S_DIV: begin
          cap_reg <= prod[23:8];
          state   <= S_DIVW;
        end

        S_DIVW: begin
          if (div_stat.done) begin
            ramp_pulses <= (div_quo > DVD_W'(cap_reg)) ? cap_reg
                                                       : div_quo[RAMP_W-1:0];
            target_pulses        <= t_reg;
            active               <= 1'b1;
            reverse              <= dist_q[15];
            peak_speed           <= (req_q != 8'd0) ? req_q : base_speed;
            elapsed_ticks        <= '0;
            last_progress_pos    <= '0;
            ticks_since_progress <= '0;
            res_left             <= '0;
            res_right            <= '0;
            res_moving           <= 1'b1;
            res_brake            <= 1'b0;
            res_reason           <= sdrc_pkg::REASON_NONE;
            state                <= FIN;
          end
        end

        T_POS: begin
          if (!active) begin
            res_left   <= '0;
            res_right  <= '0;
            res_moving <= 1'b0;
            res_brake  <= 1'b0;
            res_reason <= sdrc_pkg::REASON_NONE;
            state      <= FIN;
          end else begin
            pos   <= (lc_mag > rc_mag) ? lc_mag : rc_mag;
            state <= T_EVAL;
          end
        end

        T_EVAL: begin
          // |heading| * gain / 4096, sign restored: truncation toward zero
          corr <= hd_q[15] ? (13'd0 - {1'b0, prod[23:12]}) : {1'b0, prod[23:12]};
          if (eval_reason != sdrc_pkg::REASON_NONE) begin
            active     <= 1'b0;
            res_left   <= '0;
            res_right  <= '0;
            res_moving <= 1'b0;
            res_brake  <= 1'b1;
            res_reason <= eval_reason;
            state      <= FIN;
          end else begin
            if (progress) begin
              last_progress_pos    <= pos;
              ticks_since_progress <= 16'd1;
            end else if (ticks_since_progress != 16'hFFFF) begin
              ticks_since_progress <= ticks_since_progress + 16'd1;
            end
            if (elapsed_ticks != 16'hFFFF) begin
              elapsed_ticks <= elapsed_ticks + 16'd1;
            end
            rem_lo   <= rem_s[RAMP_W-1:0];
            span_neg <= peak_speed < min_speed;
            span_mag <= (peak_speed < min_speed) ? (min_speed - peak_speed)
                                                 : (peak_speed - min_speed);
            if (rem_in_ramp) begin
              state <= T_MULR;
            end else begin
              speed <= peak_speed;
              state <= T_DRIVE;
            end
          end
        end

        T_MULR: begin
          state <= T_DIVS;
        end

        T_DIVS: begin
          state <= T_DIVW;
        end

        T_DIVW: begin
          if (div_stat.done) begin
            // quotient stays below |peak - min|, so eight bits hold it
            speed <= span_neg ? (min_speed - div_quo[7:0]) : (min_speed + div_quo[7:0]);
            state <= T_DRIVE;
          end
        end

        T_DRIVE: begin
          res_left   <= reverse ? (9'd0 - {1'b0, l_mag}) : {1'b0, l_mag};
          res_right  <= reverse ? (9'd0 - {1'b0, r_mag}) : {1'b0, r_mag};
          res_moving <= 1'b1;
          res_brake  <= 1'b0;
          res_reason <= sdrc_pkg::REASON_NONE;
          state      <= FIN;
        end

        FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            left_drive  <= res_left;
            right_drive <= res_right;
            moving      <= res_moving;
            brake       <= res_brake;
            end_reason  <= res_reason;
            state       <= IDLE;
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `SDRC_ASSERT_ALWAYS(a_reset_clears, rst |=> (!out_valid && !in_stall), "reset left block busy")
  `SDRC_ASSERT(a_div_owned, div_stat.busy |-> (state == S_DIVW || state == T_DIVW), "divider busy outside wait")
  `SDRC_ASSERT(a_brake_ends, (out_valid && brake) |-> (!moving && end_reason != sdrc_pkg::REASON_NONE), "brake without end")
  `SDRC_ASSERT(a_drive_moving, (out_valid && (left_drive != 9'sd0 || right_drive != 9'sd0)) |-> moving, "drive while not moving")
  `SDRC_ASSERT(a_ramp_in_target, active |-> (TGT_W'(ramp_pulses) <= target_pulses), "ramp longer than move")

endmodule

@@ hw/rtl/sdrc_div.sv @@
// shared restoring divider, one quotient bit per cycle
module sdrc_div #(
  parameter int DVD_W = sdrc_pkg::DIV_DVD_W,
  parameter int DVS_W = sdrc_pkg::DIV_DVS_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DVD_W-1:0]    dividend,
  input  logic [DVS_W-1:0]    divisor,
  output logic [DVD_W-1:0]    quotient,
  output sdrc_pkg::div_stat_t stat
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             done;

  logic [DVS_W:0] shifted;
  logic [DVS_W:0] trial;
  logic           fits;

  assign shifted = {rem, quo[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
        cnt <= CNT_W'(DVD_W);
      end else if (cnt != '0) begin
        rem  <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
        quo  <= {quo[DVD_W-2:0], fits};
        cnt  <= cnt - CNT_W'(1);
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

@@ tb/sv/tb_straight_drive_ramp_controller_core.sv @@
// self-checking testbench of the straight drive ramp controller core
`timescale 1ns / 100ps

module tb_straight_drive_ramp_controller_core;

  localparam int CW = sdrc_pkg::COUNT_WIDTH_DEF;
  localparam longint CNT_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam int PHASE_ITEMS = 236;
  localparam int END_SETTLE = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_CAP = 30;

  // one input transaction, fields at the port widths
  typedef struct packed {
    logic                 func;
    logic signed [15:0]   dist_val;
    logic [7:0]           peak_req;
    logic signed [CW-1:0] lcnt;
    logic signed [CW-1:0] rcnt;
    logic signed [15:0]   hdg;
    logic                 stop;
  } move_item_t;

  // one output transaction
  typedef struct packed {
    logic signed [8:0] ldrv;
    logic signed [8:0] rdrv;
    logic              mv;
    logic              brk;
    logic [2:0]        why;
  } drive_res_t;

  // full register set, in register order
  typedef struct packed {
    logic [15:0] ppc;
    logic [7:0]  base;
    logic [7:0]  vmin;
    logic [7:0]  gain;
    logic [15:0] move_to;
    logic [15:0] stall_to;
    logic [7:0]  cap;
  } reg_set_t;

  // directed table row: either a register write or a transaction,
  // optionally with a hand-written expected result
  typedef struct {
    bit                             is_cfg;
    logic [sdrc_pkg::REG_IDX_W-1:0] reg_idx;
    logic [15:0]                    reg_val;
    move_item_t                     it;
    bit                             typed;
    drive_res_t                     res;
  } dir_row_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // dut ports
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          func = 1'b0;
  logic signed [15:0]            distance_cm = '0;
  logic [7:0]                    peak_speed_request = '0;
  logic signed [CW-1:0]          left_count = '0;
  logic signed [CW-1:0]          right_count = '0;
  logic signed [15:0]            heading = '0;
  logic                          stop_request = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [8:0]             left_drive;
  logic signed [8:0]             right_drive;
  logic                          moving;
  logic                          brake;
  logic [2:0]                    end_reason;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [sdrc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // shadow of the configuration registers
  reg_set_t cfg;

  // predicted move state
  logic        mv_active;
  logic        mv_rev;
  logic [31:0] tgt_pulses;
  logic [31:0] ramp_len;
  logic [7:0]  peak_spd;
  logic [15:0] elapsed;
  logic [23:0] last_pos;
  logic [15:0] since_prog;

  drive_res_t expected_drives[$];
  dir_row_t   dir_rows[$];
  int         mismatches = 0;
  int         burst_left = 0;
  int         idle_cycles = 0;
  rx_mode_t   rx_mode = RX_FREE;
  int         rx_left = 0;

  straight_drive_ramp_controller_core i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .func               (func),
    .distance_cm        (distance_cm),
    .peak_speed_request (peak_speed_request),
    .left_count         (left_count),
    .right_count        (right_count),
    .heading            (heading),
    .stop_request       (stop_request),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .left_drive         (left_drive),
    .right_drive        (right_drive),
    .moving             (moving),
    .brake              (brake),
    .end_reason         (end_reason),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #5 clk = ~clk;

  // computes the drive result of one transaction and advances the move state
  task automatic drive_predict(input move_item_t it, output drive_res_t r);
    longint d, mag, t, rl, capl, ppc, la, ra, pos, remaining, diff;
    longint spd, pk, mn, corr, ml, mr, hd;
    logic [2:0] why;
    r = '0;
    ppc = cfg.ppc;
    if (it.func == sdrc_pkg::FUNC_START) begin
      d = it.dist_val;
      if (d == 0) begin
        // zero distance leaves any move alone
        r.mv = mv_active;
      end else begin
        mag = (d < 0) ? -d : d;
        t = (mag * ppc) >> 12;
        rl = t / 5;
        capl = cfg.cap;
        capl = (capl * ppc) >> 8;
        if (rl > capl) rl = capl;
        mv_active = 1'b1;
        mv_rev = (d < 0);
        tgt_pulses = t[31:0];
        ramp_len = rl[31:0];
        peak_spd = (it.peak_req != 0) ? it.peak_req : cfg.base;
        elapsed = '0;
        last_pos = '0;
        since_prog = '0;
        r.mv = 1'b1;
      end
    end else if (mv_active) begin
      la = it.lcnt;
      ra = it.rcnt;
      if (la < 0) la = -la;
      if (ra < 0) ra = -ra;
      pos = (la > ra) ? la : ra;
      remaining = tgt_pulses;
      remaining = remaining - pos;
      diff = last_pos;
      diff = pos - diff;
      if (diff < 0) diff = -diff;
      // end checks in priority order, progress refresh sits between timeout and stall
      why = sdrc_pkg::REASON_NONE;
      if (remaining <= 0) why = sdrc_pkg::REASON_REACHED;
      else if (it.stop) why = sdrc_pkg::REASON_STOP;
      else if (elapsed > cfg.move_to) why = sdrc_pkg::REASON_TIMEOUT;
      else if (diff * 512 > ppc) begin
        last_pos = pos[23:0];
        since_prog = '0;
      end else if (since_prog > cfg.stall_to) why = sdrc_pkg::REASON_STALL;
      if (why != sdrc_pkg::REASON_NONE) begin
        mv_active = 1'b0;
        r.brk = 1'b1;
        r.why = why;
      end else begin
        pk = peak_spd;
        mn = cfg.vmin;
        rl = ramp_len;
        spd = pk;
        // linear ramp toward min speed, quotient truncated toward zero
        if (remaining < rl) spd = mn + (remaining * (pk - mn)) / rl;
        hd = it.hdg;
        corr = (hd * longint'(cfg.gain)) / 4096;
        ml = spd - corr;
        mr = spd + corr;
        if (ml < 0) ml = 0;
        else if (ml > 255) ml = 255;
        if (mr < 0) mr = 0;
        else if (mr > 255) mr = 255;
        if (mv_rev) begin
          ml = -ml;
          mr = -mr;
        end
        if (elapsed != 16'hFFFF) elapsed++;
        if (since_prog != 16'hFFFF) since_prog++;
        r.ldrv = ml[8:0];
        r.rdrv = mr[8:0];
        r.mv = 1'b1;
      end
    end
  endtask

  // puts one transaction on the input channel, bursts with random gaps
  task automatic send_move_item(input move_item_t it, input bit typed, input drive_res_t res);
    drive_res_t pred;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    func <= it.func;
    distance_cm <= it.dist_val;
    peak_speed_request <= it.peak_req;
    left_count <= it.lcnt;
    right_count <= it.rcnt;
    heading <= it.hdg;
    stop_request <= it.stop;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    drive_predict(it, pred);
    expected_drives.push_back(typed ? res : pred);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    @(posedge clk);
    burst_left = 0;
  endtask

  // setup then access phase; the register takes the value at the access edge
  task automatic write_reg(input logic [sdrc_pkg::REG_IDX_W-1:0] idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      sdrc_pkg::REG_PULSES_PER_CM: cfg.ppc = val;
      sdrc_pkg::REG_BASE_SPEED:    cfg.base = val[7:0];
      sdrc_pkg::REG_MIN_SPEED:     cfg.vmin = val[7:0];
      sdrc_pkg::REG_HEADING_GAIN:  cfg.gain = val[7:0];
      sdrc_pkg::REG_MOVE_TIMEOUT:  cfg.move_to = val;
      sdrc_pkg::REG_STALL_TIMEOUT: cfg.stall_to = val;
      sdrc_pkg::REG_RAMP_CAP_CM:   cfg.cap = val[7:0];
      default: ;
    endcase
  endtask

  function automatic dir_row_t blank_row();
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.it = '0;
    r.typed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic dir_row_t tick_row(input longint lc, input longint rc, input int hd,
                                        input bit stp);
    dir_row_t r;
    r = blank_row();
    r.it.func = sdrc_pkg::FUNC_TICK;
    r.it.lcnt = lc[CW-1:0];
    r.it.rcnt = rc[CW-1:0];
    r.it.hdg = hd[15:0];
    r.it.stop = stp;
    return r;
  endfunction

  function automatic dir_row_t start_row(input int dv, input int req);
    dir_row_t r;
    r = blank_row();
    r.it.func = sdrc_pkg::FUNC_START;
    r.it.dist_val = dv[15:0];
    r.it.peak_req = req[7:0];
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [sdrc_pkg::REG_IDX_W-1:0] idx,
                                       input logic [15:0] val);
    dir_row_t r;
    r = blank_row();
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // hand-written result: drives are always zero on these rows
  function automatic dir_row_t expect_row(input dir_row_t row, input bit mv, input bit brk,
                                          input logic [2:0] why);
    dir_row_t r;
    r = row;
    r.typed = 1'b1;
    r.res = '0;
    r.res.mv = mv;
    r.res.brk = brk;
    r.res.why = why;
    return r;
  endfunction

  function automatic reg_set_t rand_set();
    reg_set_t s;
    s.ppc = 16'($urandom_range(1, 65535));
    s.base = 8'($urandom);
    s.vmin = 8'($urandom);
    s.gain = 8'($urandom);
    s.move_to = 16'($urandom_range(0, 300));
    s.stall_to = 16'($urandom_range(0, 30));
    s.cap = 8'($urandom);
    return s;
  endfunction

  // one register setting, then mostly well-formed moves with some noise
  task automatic run_phase(input reg_set_t s, input int n);
    move_item_t it;
    logic [95:0] rnd;
    drive_res_t none;
    int sent, pick, hold_left, dv, sel, h, jit;
    longint pos_mag, step, other, lv, rv;
    bit eff, start_move, swap;
    none = '0;
    wait_results_drained();
    write_reg(sdrc_pkg::REG_PULSES_PER_CM, s.ppc);
    write_reg(sdrc_pkg::REG_BASE_SPEED, {8'd0, s.base});
    write_reg(sdrc_pkg::REG_MIN_SPEED, {8'd0, s.vmin});
    write_reg(sdrc_pkg::REG_HEADING_GAIN, {8'd0, s.gain});
    write_reg(sdrc_pkg::REG_MOVE_TIMEOUT, s.move_to);
    write_reg(sdrc_pkg::REG_STALL_TIMEOUT, s.stall_to);
    write_reg(sdrc_pkg::REG_RAMP_CAP_CM, {8'd0, s.cap});
    sent = 0;
    hold_left = 0;
    pos_mag = 0;
    step = 1;
    while (sent < n) begin
      it = '0;
      start_move = 1'b0;
      pick = $urandom_range(0, 99);
      if ((!mv_active && pick < 72) || (mv_active && pick < 3)) begin
        // new move, replacing one in progress now and then
        start_move = 1'b1;
        sel = $urandom_range(0, 9);
        if (sel < 8) dv = $urandom_range(1, 800);
        else if (sel == 8) dv = $urandom_range(1, 32767);
        else dv = 32767;
        if ($urandom_range(0, 1) == 1) dv = (sel == 9) ? -32768 : -dv;
        it.func = sdrc_pkg::FUNC_START;
        it.dist_val = dv[15:0];
        it.peak_req = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
      end else if ((!mv_active && pick < 84) || (mv_active && pick < 5)) begin
        it.func = sdrc_pkg::FUNC_START;
        it.peak_req = 8'($urandom);
      end else if (!mv_active || pick < 8) begin
        // noise: every field random
        rnd = {$urandom, $urandom, $urandom};
        it = rnd[$bits(move_item_t)-1:0];
      end else begin
        // tick of a move in progress: position creeps toward the target
        if (hold_left > 0) begin
          hold_left--;
        end else if ($urandom_range(0, 19) == 0) begin
          hold_left = $urandom_range(1, 12);
        end else if ($urandom_range(0, 19) == 0) begin
          jit = $urandom_range(0, int'(step));
          pos_mag = pos_mag - jit;
        end else begin
          jit = $urandom_range(0, int'(step));
          pos_mag = pos_mag + step / 2 + jit;
        end
        if (pos_mag < 0) pos_mag = 0;
        if (pos_mag > CNT_MAX) pos_mag = CNT_MAX;
        jit = $urandom_range(0, int'(step));
        other = pos_mag - jit;
        if (other < 0) other = 0;
        swap = $urandom_range(0, 1);
        lv = swap ? other : pos_mag;
        rv = swap ? pos_mag : other;
        if (mv_rev ^ ($urandom_range(0, 15) == 0)) lv = -lv;
        if (mv_rev ^ ($urandom_range(0, 15) == 0)) rv = -rv;
        sel = $urandom_range(0, 9);
        if (sel < 7) h = $urandom_range(0, 4095) - 2048;
        else if (sel < 9) h = $urandom_range(0, 32767) - 16384;
        else h = $urandom;
        it.func = sdrc_pkg::FUNC_TICK;
        it.lcnt = lv[CW-1:0];
        it.rcnt = rv[CW-1:0];
        it.hdg = h[15:0];
        it.stop = ($urandom_range(0, 59) == 0);
      end
      // idle ticks and zero-distance starts do not move anything
      eff = (it.func == sdrc_pkg::FUNC_START) ? (it.dist_val != 0) : mv_active;
      send_move_item(it, 1'b0, none);
      if (eff) sent++;
      if (start_move) begin
        step = tgt_pulses;
        step = step / $urandom_range(4, 30);
        if (step < 1) step = 1;
        pos_mag = 0;
        hold_left = 0;
      end
      if ($urandom_range(0, 199) == 0) wait_results_drained();
    end
  endtask

  // receiver: stall pattern switches between free, light, heavy and periodic
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(40, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= ((rx_left % 23) < 9);
    endcase
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      if (mismatches < PRINT_CAP)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    drive_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_drives.size() == 0) begin
        if (mismatches < PRINT_CAP)
          $display("%0t ns: result with nothing expected, expected none, got %0d %0d %0d %0d %0d",
                   $time, left_drive, right_drive, moving, brake, end_reason);
        mismatches++;
      end else begin
        want = expected_drives.pop_front();
        check_field("left_drive", int'(want.ldrv), int'(left_drive));
        check_field("right_drive", int'(want.rdrv), int'(right_drive));
        check_field("moving", int'(want.mv), int'(moving));
        check_field("brake", int'(want.brk), int'(brake));
        check_field("end_reason", int'(want.why), int'(end_reason));
      end
    end
  end

  // watchdog: too long without any transaction or register access
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_straight_drive_ramp_controller_core NOT OK");
      $finish;
    end
  end

  initial begin
    cfg = reg_set_t'{sdrc_pkg::RST_PULSES_PER_CM, sdrc_pkg::RST_BASE_SPEED,
                     sdrc_pkg::RST_MIN_SPEED, sdrc_pkg::RST_HEADING_GAIN,
                     sdrc_pkg::RST_MOVE_TIMEOUT, sdrc_pkg::RST_STALL_TIMEOUT,
                     sdrc_pkg::RST_RAMP_CAP_CM};
    mv_active = 1'b0;
    mv_rev = 1'b0;
    tgt_pulses = '0;
    ramp_len = '0;
    peak_spd = '0;
    elapsed = '0;
    last_pos = '0;
    since_prog = '0;

    // directed part, register defaults: 160 cm is 400 pulses with an 80 pulse ramp
    dir_rows.push_back(expect_row(tick_row(CNT_MAX, -CNT_MAX - 1, -32768, 1'b1),
                                  1'b0, 1'b0, sdrc_pkg::REASON_NONE));
    dir_rows.push_back(expect_row(start_row(0, 255), 1'b0, 1'b0, sdrc_pkg::REASON_NONE));
    dir_rows.push_back(expect_row(start_row(160, 0), 1'b1, 1'b0, sdrc_pkg::REASON_NONE));
    dir_rows.push_back(tick_row(0, 0, 0, 1'b0));
    // heading extremes saturate one side and zero the other
    dir_rows.push_back(tick_row(100, -50, 32767, 1'b0));
    dir_rows.push_back(tick_row(-200, 150, -32768, 1'b0));
    // inside the ramp zone
    dir_rows.push_back(tick_row(350, 0, 256, 1'b0));
    dir_rows.push_back(expect_row(start_row(0, 0), 1'b1, 1'b0, sdrc_pkg::REASON_NONE));
    dir_rows.push_back(expect_row(tick_row(-CNT_MAX - 1, CNT_MAX, 0, 1'b0),
                                  1'b0, 1'b1, sdrc_pkg::REASON_REACHED));
    // longest reverse move, then replaced by the longest forward one
    dir_rows.push_back(expect_row(start_row(-32768, 255), 1'b1, 1'b0,
                                  sdrc_pkg::REASON_NONE));
    dir_rows.push_back(tick_row(-1000, -500, 0, 1'b0));
    dir_rows.push_back(expect_row(start_row(32767, 1), 1'b1, 1'b0, sdrc_pkg::REASON_NONE));
    dir_rows.push_back(expect_row(tick_row(0, 0, 0, 1'b1), 1'b0, 1'b1,
                                  sdrc_pkg::REASON_STOP));
    // zero move timeout: the second tick aborts
    dir_rows.push_back(cfg_row(sdrc_pkg::REG_MOVE_TIMEOUT, 16'd0));
    dir_rows.push_back(expect_row(start_row(16, 50), 1'b1, 1'b0, sdrc_pkg::REASON_NONE));
    dir_rows.push_back(tick_row(0, 0, -100, 1'b0));
    dir_rows.push_back(expect_row(tick_row(0, 0, 0, 1'b0), 1'b0, 1'b1,
                                  sdrc_pkg::REASON_TIMEOUT));
    // saturated move timeout never fires, zero stall timeout does
    dir_rows.push_back(cfg_row(sdrc_pkg::REG_MOVE_TIMEOUT, 16'hFFFF));
    dir_rows.push_back(cfg_row(sdrc_pkg::REG_STALL_TIMEOUT, 16'd0));
    dir_rows.push_back(expect_row(start_row(-16, 0), 1'b1, 1'b0, sdrc_pkg::REASON_NONE));
    dir_rows.push_back(tick_row(0, 0, 0, 1'b0));
    dir_rows.push_back(expect_row(tick_row(0, 0, 0, 1'b0), 1'b0, 1'b1,
                                  sdrc_pkg::REASON_STALL));
    // zero pulses per cm: a zero target, reached on the first tick
    dir_rows.push_back(cfg_row(sdrc_pkg::REG_PULSES_PER_CM, 16'd0));
    dir_rows.push_back(expect_row(start_row(100, 0), 1'b1, 1'b0, sdrc_pkg::REASON_NONE));
    dir_rows.push_back(expect_row(tick_row(0, 0, 0, 1'b0), 1'b0, 1'b1,
                                  sdrc_pkg::REASON_REACHED));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_results_drained();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_move_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // random part over several register settings, extremes included
    run_phase(reg_set_t'{sdrc_pkg::RST_PULSES_PER_CM, sdrc_pkg::RST_BASE_SPEED,
                         sdrc_pkg::RST_MIN_SPEED, sdrc_pkg::RST_HEADING_GAIN,
                         sdrc_pkg::RST_MOVE_TIMEOUT, sdrc_pkg::RST_STALL_TIMEOUT,
                         sdrc_pkg::RST_RAMP_CAP_CM}, PHASE_ITEMS);
    run_phase(reg_set_t'{16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF},
              PHASE_ITEMS);
    run_phase(reg_set_t'{16'd1, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0}, PHASE_ITEMS);
    // min above peak gives a rising ramp; short timeouts make aborts common
    run_phase(reg_set_t'{16'd512, 8'd60, 8'd220, 8'd255, 16'd40, 16'd6, 8'd3}, PHASE_ITEMS);
    run_phase(reg_set_t'{16'd2560, 8'd0, 8'd255, 8'd16, 16'd200, 16'd20, 8'd255},
              PHASE_ITEMS);
    run_phase(rand_set(), PHASE_ITEMS);
    run_phase(rand_set(), PHASE_ITEMS);

    wait_results_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("tb_straight_drive_ramp_controller_core OK");
    else
      $display("tb_straight_drive_ramp_controller_core NOT OK");
    $finish;
  end

endmodule
